// ===== rtl/core/cis_pkg.sv =====
package cis_pkg;

   // Sizing
   localparam int CAPACITY = 16;
   localparam int ID_WIDTH = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Command codes
   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_LOOKUP = 2'd2
   } cmd_type;

   // Request payload
   typedef struct packed {
      logic [1:0]          cmd;
      logic [ID_WIDTH-1:0] ident;
   } req_type;

   // Response payload
   typedef struct packed {
      logic             status;
      logic             found;
      logic [CNT_W-1:0] count;
      logic             is_empty;
      logic             is_full;
   } rsp_type;

   // Write controls broadcast to every cell
   typedef struct packed {
      logic add_en;
      logic del_en;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/cis_cell.sv =====
module cis_cell (
   input  logic                            clock,
   input  cis_pkg::cell_ctrl_type          ctrl,
   input  logic [cis_pkg::ID_WIDTH-1:0]    ident,
   input  logic [cis_pkg::IDX_W-1:0]       idx,
   input  logic [cis_pkg::CNT_W-1:0]       count,
   input  logic                            hit_in,
   output logic                            hit_out,
   input  logic [cis_pkg::ID_WIDTH-1:0]    next_entry,
   output logic [cis_pkg::ID_WIDTH-1:0]    entry
);

   logic [cis_pkg::ID_WIDTH-1:0] entry_ff;
   logic [cis_pkg::ID_WIDTH-1:0] entry_in;
   logic [cis_pkg::CNT_W-1:0]    my_pos;
   logic                         occupied;
   logic                         hit;

   assign my_pos   = cis_pkg::CNT_W'(idx);
   assign occupied = (my_pos < count);

   // Match chain: only occupied cells take part
   assign hit     = occupied && (entry_ff == ident);
   assign hit_out = hit_in | hit;

   // Append lands in the first free cell; delete pulls from the right
   // neighbor in every cell at or after the first match
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.add_en && (my_pos == count)) begin
         entry_in = ident;
      end else if (ctrl.del_en && hit_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/core/compacting_id_set_unit.sv =====
// Compacting identifier set: holds up to CAPACITY identifiers in a row of
// cells, oldest first, with no gaps. Add appends at the end (duplicates are
// kept), delete drops the first match and the later cells each move one
// place toward the front, lookup reports membership. Every command goes
// through the cell row and gives exactly one response, registered at the
// output; a new command is taken every cycle unless a response is held
// by rsp_stall. The null marker register (reset all ones) is written over
// the csr port, which is always ready, and should change only while idle.
module compacting_id_set_unit (
   input  logic                          clock,
   input  logic                          reset,
   // Command channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cis_pkg::req_type              req_data,
   // Response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cis_pkg::rsp_type              rsp_data,
   // Null marker write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cis_pkg::ID_WIDTH-1:0]  csr_data
);

   logic [cis_pkg::CNT_W-1:0]    count_ff;
   logic [cis_pkg::CNT_W-1:0]    count_in;
   logic [cis_pkg::ID_WIDTH-1:0] null_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   cis_pkg::rsp_type             rsp_ff;
   cis_pkg::rsp_type             rsp_in;

   logic                         take;
   logic                         is_null;
   logic                         is_full_now;
   logic                         any_hit;
   cis_pkg::cell_ctrl_type       ctrl;
   logic                         status;
   logic                         found;

   logic [cis_pkg::CAPACITY:0]   hit_chain;
   logic [cis_pkg::ID_WIDTH-1:0] entry_row [cis_pkg::CAPACITY];

   // Handshakes
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign is_null     = (req_data.ident == null_ff);
   assign is_full_now = (count_ff == cis_pkg::CNT_W'(cis_pkg::CAPACITY));
   assign any_hit     = hit_chain[cis_pkg::CAPACITY];

   // Command decode
   always_comb begin
      ctrl.add_en = 1'b0;
      ctrl.del_en = 1'b0;
      status      = 1'b1;
      found       = 1'b0;
      unique case (req_data.cmd)
         cis_pkg::CMD_ADD: begin
            status      = is_null | is_full_now;
            ctrl.add_en = take & ~is_null & ~is_full_now;
         end
         cis_pkg::CMD_DELETE: begin
            status      = is_null | ~any_hit;
            ctrl.del_en = take & ~is_null & any_hit;
         end
         cis_pkg::CMD_LOOKUP: begin
            status = 1'b0;
            found  = any_hit;
         end
         default: begin
            status = 1'b1;
         end
      endcase
   end

   // Cell row
   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < cis_pkg::CAPACITY; i++) begin : g_cell
      logic [cis_pkg::ID_WIDTH-1:0] next_entry;

      if (i == cis_pkg::CAPACITY - 1) begin : g_last
         assign next_entry = entry_row[i];
      end else begin : g_mid
         assign next_entry = entry_row[i+1];
      end

      cis_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .ident      (req_data.ident),
         .idx        (cis_pkg::IDX_W'(i)),
         .count      (count_ff),
         .hit_in     (hit_chain[i]),
         .hit_out    (hit_chain[i+1]),
         .next_entry (next_entry),
         .entry      (entry_row[i])
      );
   end

   // Count and response
   always_comb begin
      count_in = count_ff;
      if (ctrl.add_en) begin
         count_in = count_ff + cis_pkg::CNT_W'(1);
      end else if (ctrl.del_en) begin
         count_in = count_ff - cis_pkg::CNT_W'(1);
      end

      rsp_in          = rsp_ff;
      rsp_in.status   = status;
      rsp_in.found    = found;
      rsp_in.count    = count_in;
      rsp_in.is_empty = (count_in == '0);
      rsp_in.is_full  = (count_in == cis_pkg::CNT_W'(cis_pkg::CAPACITY));

      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         null_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            null_ff <= csr_data;
         end
      end
   end

   // Payload holds while stalled
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
